[rtl/core/joystick_zone_mapper_unit_assert.svh]
// ----------------------------------------------------------------------------
// joystick_zone_mapper_unit_assert.svh
// Assertion macros for the joystick zone mapper; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_ZONE_MAPPER_UNIT_ASSERT_SVH
`define JOYSTICK_ZONE_MAPPER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define JZM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jzm: implication check failed");
`define JZM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jzm: next-cycle check failed");
`else
`define JZM_ASSERT_IMP(lbl, ante, cons)
`define JZM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/core/jzm_pkg.sv]
// ----------------------------------------------------------------------------
// jzm_pkg
// Shared types and constants of the joystick zone mapper.
// ----------------------------------------------------------------------------
package jzm_pkg;

  localparam int AXIS_W    = 8;
  localparam int RECT_BITS = 11;
  localparam int RECT_W    = 4 * RECT_BITS;
  localparam int MAX_ZONES = 6;
  localparam int CFG_IDX_W = 3;
  localparam int ZONE_W    = 3;

  typedef logic [2:0]        mode_t;
  typedef logic [1:0]        event_t;
  typedef logic [RECT_W-1:0] rect_t;

  localparam mode_t MODE_KEYS       = 3'd0;
  localparam mode_t MODE_ABS        = 3'd1;
  localparam mode_t MODE_CAL_CENTER = 3'd2;
  localparam mode_t MODE_CAL_BOUNDS = 3'd3;
  localparam mode_t MODE_CAL_NORTH  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE0_RECT  = 3'd2;

  localparam event_t EV_PRESS   = 2'd0;
  localparam event_t EV_RELEASE = 2'd1;
  localparam event_t EV_ABS_X   = 2'd2;
  localparam event_t EV_ABS_Y   = 2'd3;

  localparam logic [AXIS_W-1:0] AXIS_MAX = 8'd255;
  localparam logic [AXIS_W-1:0] AXIS_MID = 8'd127;

  localparam rect_t RECT_RESET [MAX_ZONES] = '{
    44'd2641405095936, 44'd7924216129536, 44'd8796952854528,
    44'd8800387990323, 44'd880468295680,  44'd8800389877760
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS_X,
    ST_ABS_Y,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_ZONE,
    ST_EMIT
  } seq_state_t;

endpackage

[rtl/core/jzm_div.sv]
// ----------------------------------------------------------------------------
// jzm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jzm_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // quot shifts dividend bits out of the top and quotient bits in at the bottom
  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quot <= {quot[NUM_W-2:0], ge};
      rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

endmodule

[rtl/core/jzm_zone_cmp.sv]
// ----------------------------------------------------------------------------
// jzm_zone_cmp
// Inclusive point-in-rectangle test for one zone.
// ----------------------------------------------------------------------------
module jzm_zone_cmp #(
  parameter int FRAC_BITS = 10
) (
  input  jzm_pkg::rect_t       rect,
  input  logic [FRAC_BITS:0]   pos_x,
  input  logic [FRAC_BITS:0]   pos_y,
  output logic                 in_rect
);

  import jzm_pkg::*;

  localparam int CW = (FRAC_BITS + 1 > RECT_BITS) ? FRAC_BITS + 1 : RECT_BITS;

  logic [CW-1:0] px, py, x1, y1, x2, y2;

  assign px = CW'(pos_x);
  assign py = CW'(pos_y);
  assign x1 = CW'(rect[RECT_BITS-1:0]);
  assign y1 = CW'(rect[2*RECT_BITS-1:RECT_BITS]);
  assign x2 = CW'(rect[3*RECT_BITS-1:2*RECT_BITS]);
  assign y2 = CW'(rect[4*RECT_BITS-1:3*RECT_BITS]);

  assign in_rect = (px >= x1) && (px <= x2) && (py >= y1) && (py <= y2);

endmodule

[rtl/core/joystick_zone_mapper_unit.sv]
// ----------------------------------------------------------------------------
// joystick_zone_mapper_unit
// Keys mode: the shared divider runs once per axis, each zone is tested in
// turn, then one event is sent per enabled zone that is hit or was active.
// Absolute mode: raw X then raw Y as two events. Calibration modes: taken in
// idle, no event. One sample at a time; stall is high while one is in work.
// Synchronous reset restores registers, calibration and zone state at once.
// ----------------------------------------------------------------------------
`include "joystick_zone_mapper_unit_assert.svh"

module joystick_zone_mapper_unit #(
  parameter int NUM_ZONES = 6,
  parameter int FRAC_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [jzm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jzm_pkg::RECT_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [jzm_pkg::AXIS_W-1:0]     raw_x,
  input  logic [jzm_pkg::AXIS_W-1:0]     raw_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jzm_pkg::event_t                event_kind,
  output logic [jzm_pkg::ZONE_W-1:0]     zone_index,
  output logic [jzm_pkg::AXIS_W-1:0]     axis_value,
  output logic                           last_event
);

  import jzm_pkg::*;

  localparam int NW    = FRAC_BITS + 1;
  localparam int DIV_W = AXIS_W - 1 + FRAC_BITS;
  localparam int ZW    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam logic [NW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NW-1:0] HALF = ONE >> 1;

  // configuration
  mode_t                 mode;
  logic [NUM_ZONES-1:0]  zone_enable;
  rect_t                 rect [NUM_ZONES];

  // calibration and zone state
  logic [AXIS_W-1:0]     center_x, center_y;
  logic [AXIS_W-1:0]     min_x, min_y, max_x, max_y;
  logic [NUM_ZONES-1:0]  zone_active;
  logic [NUM_ZONES-1:0]  emit_mask;

  // per-sample work registers
  logic [AXIS_W-1:0]     sx, sy;
  logic [NW-1:0]         nx, ny;
  logic [ZW-1:0]         zc, zc_next;
  seq_state_t            state, state_next;

  // sequencer controls
  logic                  accept, out_free, div_start, div_done;
  logic                  cap_x, cap_y, zone_upd, zc_last, rest;
  logic                  out_load, out_last_n;
  event_t                out_kind_n;
  logic [AXIS_W-1:0]     out_val_n;

  // axis setup and quotient fix-up
  logic                  sel_y, below, span_zero, q_neg, q_nz, q_big, hit;
  logic [AXIS_W-1:0]     v, c, lo, hi;
  logic [AXIS_W:0]       d9, a9, d_neg, a_neg;
  logic [AXIS_W-1:0]     d_mag, a_mag;
  logic [DIV_W-1:0]      div_num, quot;
  logic [NW-1:0]         q_low, norm;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign zc_last  = (zc == ZW'(NUM_ZONES - 1));

  // --------------------------------------------------------------------------
  // Axis normalization setup; the divisor 2*span is folded into the dividend
  // --------------------------------------------------------------------------
  assign sel_y = (state == ST_START_Y) || (state == ST_WAIT_Y);
  assign v     = sel_y ? sy : sx;
  assign c     = sel_y ? center_y : center_x;
  assign lo    = sel_y ? min_y : min_x;
  assign hi    = sel_y ? max_y : max_x;
  assign below = (v <= c);

  assign d9 = below ? ({1'b0, c} - {1'b0, lo}) : ({1'b0, hi} - {1'b0, c});
  assign a9 = below ? ({1'b0, v} - {1'b0, lo}) : ({1'b0, hi} - {1'b0, v});
  assign d_neg = '0 - d9;
  assign a_neg = '0 - a9;
  assign d_mag = d9[AXIS_W] ? d_neg[AXIS_W-1:0] : d9[AXIS_W-1:0];
  assign a_mag = a9[AXIS_W] ? a_neg[AXIS_W-1:0] : a9[AXIS_W-1:0];
  assign span_zero = (d9 == '0);
  assign q_neg     = a9[AXIS_W] ^ d9[AXIS_W];
  assign div_num   = {a_mag, {(FRAC_BITS - 1){1'b0}}};

  jzm_div #(
    .NUM_W (DIV_W),
    .DEN_W (AXIS_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (d_mag),
    .done  (div_done),
    .quot  (quot)
  );

  assign q_nz  = (quot != '0);
  assign q_big = (quot > DIV_W'(ONE));
  assign q_low = quot[NW-1:0];

  // truncation toward zero, then clamp to 0..ONE
  always_comb begin
    if (span_zero) begin
      norm = HALF;
    end else if (below) begin
      if (q_neg && q_nz) norm = '0;
      else if (q_big)    norm = ONE;
      else               norm = q_low;
    end else begin
      if (q_neg && q_nz) norm = ONE;
      else if (q_big)    norm = '0;
      else               norm = ONE - q_low;
    end
  end

  jzm_zone_cmp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_zone_cmp (
    .rect    (rect[zc]),
    .pos_x   (nx),
    .pos_y   (ny),
    .in_rect (hit)
  );

  // any zone after the current one still to report
  always_comb begin
    rest = 1'b0;
    for (int i = 0; i < NUM_ZONES; i++) begin
      if ((ZW'(i) > zc) && emit_mask[i]) rest = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      zc    <= '0;
    end else begin
      state <= state_next;
      zc    <= zc_next;
    end
  end

  always_comb begin
    state_next = state;
    zc_next    = zc;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    cap_x      = 1'b0;
    cap_y      = 1'b0;
    zone_upd   = 1'b0;
    out_load   = 1'b0;
    out_kind_n = EV_PRESS;
    out_val_n  = '0;
    out_last_n = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (mode)
            MODE_KEYS: state_next = ST_START_X;
            MODE_ABS:  state_next = ST_ABS_X;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ABS_X: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_n = EV_ABS_X;
          out_val_n  = sx;
          state_next = ST_ABS_Y;
        end
      end
      ST_ABS_Y: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind_n = EV_ABS_Y;
          out_val_n  = sy;
          out_last_n = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_START_X: begin
        div_start  = 1'b1;
        state_next = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (div_done) begin
          cap_x      = 1'b1;
          state_next = ST_START_Y;
        end
      end
      ST_START_Y: begin
        div_start  = 1'b1;
        state_next = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        if (div_done) begin
          cap_y      = 1'b1;
          zc_next    = '0;
          state_next = ST_ZONE;
        end
      end
      ST_ZONE: begin
        zone_upd = 1'b1;
        if (zc_last) begin
          zc_next    = '0;
          state_next = ST_EMIT;
        end else begin
          zc_next = zc + ZW'(1);
        end
      end
      ST_EMIT: begin
        if (!emit_mask[zc] || out_free) begin
          out_load   = emit_mask[zc];
          out_kind_n = zone_active[zc] ? EV_PRESS : EV_RELEASE;
          out_last_n = !rest;
          if (zc_last) begin
            zc_next    = '0;
            state_next = ST_IDLE;
          end else begin
            zc_next = zc + ZW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration and calibration state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_KEYS;
      zone_enable <= {NUM_ZONES{1'b1}};
      for (int i = 0; i < NUM_ZONES; i++) rect[i] <= RECT_RESET[i];
      center_x    <= AXIS_MID;
      center_y    <= AXIS_MID;
      min_x       <= '0;
      min_y       <= '0;
      max_x       <= AXIS_MAX;
      max_y       <= AXIS_MAX;
    end else begin
      if (cfg_we && (cfg_index == REG_MODE) && (cfg_data[2:0] != mode)) begin
        mode <= cfg_data[2:0];
        // entering bounds calibration starts from inverted bounds
        if (cfg_data[2:0] == MODE_CAL_BOUNDS) begin
          min_x <= AXIS_MAX;
          min_y <= AXIS_MAX;
          max_x <= '0;
          max_y <= '0;
        end
      end
      if (cfg_we && (cfg_index == REG_ZONE_ENABLE)) begin
        zone_enable <= cfg_data[NUM_ZONES-1:0];
      end
      for (int i = 0; i < NUM_ZONES; i++) begin
        if (cfg_we && (cfg_index == CFG_IDX_W'(int'(REG_ZONE0_RECT) + i))) begin
          rect[i] <= cfg_data;
        end
      end
      if (accept) begin
        case (mode)
          MODE_CAL_CENTER: begin
            center_x <= raw_x;
            center_y <= raw_y;
          end
          MODE_CAL_BOUNDS: begin
            if (raw_x < min_x) min_x <= raw_x;
            if (raw_y < min_y) min_y <= raw_y;
            if (raw_x > max_x) max_x <= raw_x;
            if (raw_y > max_y) max_y <= raw_y;
          end
          MODE_CAL_NORTH: begin
            // north point has no effect on any event
          end
          default: begin
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Zone state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_active <= '0;
      emit_mask   <= '0;
    end else if (zone_upd) begin
      if (zone_enable[zc]) begin
        zone_active[zc] <= hit;
        emit_mask[zc]   <= hit || zone_active[zc];
      end else begin
        emit_mask[zc] <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample and normalized position
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      sx <= raw_x;
      sy <= raw_y;
    end
    if (cap_x) nx <= norm;
    if (cap_y) ny <= norm;
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_kind <= out_kind_n;
      zone_index <= (state == ST_EMIT) ? ZONE_W'(zc) : '0;
      axis_value <= out_val_n;
      last_event <= out_last_n;
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `JZM_ASSERT_NXT(a_busy_after_accept, accept && (mode <= MODE_ABS), in_stall)
  `JZM_ASSERT_IMP(a_div_done_in_wait, div_done, state == ST_WAIT_X || state == ST_WAIT_Y)
  `JZM_ASSERT_IMP(a_more_pending, out_valid && !last_event, state != ST_IDLE)

endmodule
